FILE: rtl/xcr_pkg.sv
`default_nettype none

package xcr_pkg;

    // Defaults for the top-level parameters
    localparam int BLOCK_BYTES_DEF = 128;
    localparam int ADDR_BITS_DEF   = 24;

    // Fixed field widths
    localparam int LEN_W  = 25;
    localparam int CFG_W  = 25;
    localparam int LIM_W  = 4;
    localparam int TICK_W = 16;
    localparam int ERR_W  = 5;
    localparam int CRC_W  = 16;

    // Protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;

    // CRC-16/XMODEM polynomial
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  CAP_RST       = 25'd16777216;
    localparam logic [LIM_W-1:0]  ERR_LIMIT_RST = 4'd10;
    localparam logic [TICK_W-1:0] INIT_TO_RST   = 16'd3000;
    localparam logic [TICK_W-1:0] BYTE_TO_RST   = 16'd1000;

    // Status codes
    localparam logic [1:0] STAT_BUSY = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_CAPACITY  = 2'd0,
        CFG_ERR_LIMIT = 2'd1,
        CFG_INIT_TO   = 2'd2,
        CFG_BYTE_TO   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_INIT  = 4'd1,
        PH_NUM   = 4'd2,
        PH_INV   = 4'd3,
        PH_DATA  = 4'd4,
        PH_CRCH  = 4'd5,
        PH_CRCL  = 4'd6,
        PH_WAIT  = 4'd7,
        PH_RETRY = 4'd8,
        PH_DONE  = 4'd9,
        PH_FAIL  = 4'd10
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]  capacity;
        logic [LIM_W-1:0]  err_limit;
        logic [TICK_W-1:0] init_to;
        logic [TICK_W-1:0] byte_to;
    } t_cfg;

    // Result fields of fixed width; the address travels beside it
    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             wr_valid;
        logic [7:0]       wr_data;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/xcr_if.sv
`default_nettype none

interface xcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface xcr_res_if
    import xcr_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 tx_valid;
    logic [7:0]           tx_byte;
    logic                 wr_valid;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [7:0]           wr_data;
    logic [1:0]           status;
    logic [LEN_W-1:0]     length;

    modport source (
        output valid, output tx_valid, output tx_byte, output wr_valid,
        output wr_addr, output wr_data, output status, output length,
        input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input wr_valid,
        input wr_addr, input wr_data, input status, input length,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/xcr_crc_byte.sv
`default_nettype none

module xcr_crc_byte
    import xcr_pkg::*;
(
    input  wire logic [CRC_W-1:0] i_crc,
    input  wire logic [7:0]       i_byte,
    output logic      [CRC_W-1:0] o_crc
);

    // Fold one byte into the CRC, MSB first
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

FILE: rtl/xcr_core.sv
`default_nettype none

module xcr_core
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_take,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [7:0]           i_rx_byte,
    input  wire t_cfg                 i_cfg,
    output t_res                      o_res,
    output logic      [ADDR_BITS-1:0] o_wr_addr
);

    localparam int IDX_W = $clog2(BLOCK_BYTES);
    localparam int SUM_W = (ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W;

    t_phase              r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [7:0]          r_exp, n_exp;
    logic [7:0]          r_gblk, n_gblk;
    logic [7:0]          r_gcmp, n_gcmp;
    logic [CRC_W-1:0]    r_crc, n_crc;
    logic [7:0]          r_crch, n_crch;
    logic [ERR_W-1:0]    r_err, n_err;
    logic [TICK_W-1:0]   r_wait, n_wait;
    logic [LEN_W-1:0]    r_len, n_len;

    logic [CRC_W-1:0]    crc_upd;
    logic                fits;
    logic [SUM_W-1:0]    addr_sum;
    logic                hdr_ok;
    logic [TICK_W:0]     wait_inc;

    xcr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (crc_upd)
    );

    // Block fits in the destination
    assign fits = ({1'b0, r_len} + (LEN_W+1)'(BLOCK_BYTES)) <= {1'b0, i_cfg.capacity};
    assign addr_sum = SUM_W'(r_len) + SUM_W'(r_idx);
    assign hdr_ok   = ((r_gblk ^ r_gcmp) == 8'hFF) && ({r_crch, i_rx_byte} == r_crc);
    assign wait_inc = {1'b0, r_wait} + (TICK_W+1)'(1);

    // Next state and result for one transaction
    always_comb begin
        logic   do_err;
        t_phase err_phase;
        do_err    = 1'b0;
        err_phase = PH_WAIT;

        n_phase = r_phase;
        n_idx   = r_idx;
        n_exp   = r_exp;
        n_gblk  = r_gblk;
        n_gcmp  = r_gcmp;
        n_crc   = r_crc;
        n_crch  = r_crch;
        n_err   = r_err;
        n_wait  = r_wait;
        n_len   = r_len;

        o_res     = '0;
        o_wr_addr = '0;

        unique case (t_req'(i_req_type))
            REQ_START: begin
                n_phase = PH_INIT;
                n_idx   = '0;
                n_exp   = 8'd1;
                n_gblk  = '0;
                n_gcmp  = '0;
                n_crc   = '0;
                n_crch  = '0;
                n_err   = '0;
                n_wait  = '0;
                n_len   = '0;
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = CH_C;
            end
            REQ_BYTE: begin
                unique case (r_phase)
                    PH_INIT: begin
                        if (i_rx_byte == CH_SOH) begin
                            n_phase = PH_NUM;
                            n_idx   = '0;
                            n_crc   = '0;
                            n_wait  = '0;
                        end else begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = CH_C;
                            n_wait         = '0;
                        end
                    end
                    PH_NUM: begin
                        n_gblk  = i_rx_byte;
                        n_phase = PH_INV;
                        n_wait  = '0;
                    end
                    PH_INV: begin
                        n_gcmp  = i_rx_byte;
                        n_phase = PH_DATA;
                        n_wait  = '0;
                    end
                    PH_DATA: begin
                        if (fits) begin
                            o_res.wr_valid = 1'b1;
                            o_res.wr_data  = i_rx_byte;
                            o_wr_addr      = addr_sum[ADDR_BITS-1:0];
                        end
                        n_crc = crc_upd;
                        n_idx = r_idx + IDX_W'(1);
                        if (r_idx == IDX_W'(BLOCK_BYTES - 1)) begin
                            n_phase = PH_CRCH;
                        end
                        n_wait = '0;
                    end
                    PH_CRCH: begin
                        n_crch  = i_rx_byte;
                        n_phase = PH_CRCL;
                        n_wait  = '0;
                    end
                    PH_CRCL: begin
                        priority if (!hdr_ok) begin
                            do_err = 1'b1;
                        end else if (r_gblk == r_exp) begin
                            if (fits) begin
                                n_len = r_len + LEN_W'(BLOCK_BYTES);
                            end
                            n_exp          = r_exp + 8'd1;
                            n_err          = '0;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = CH_ACK;
                            n_phase        = PH_WAIT;
                            n_wait         = '0;
                        end else if (r_gblk == (r_exp - 8'd1)) begin
                            // Repeat of the last block: acknowledge, store nothing
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = CH_ACK;
                            n_phase        = PH_WAIT;
                            n_wait         = '0;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    PH_WAIT, PH_RETRY: begin
                        priority if (i_rx_byte == CH_SOH) begin
                            n_phase = PH_NUM;
                            n_idx   = '0;
                            n_crc   = '0;
                            n_wait  = '0;
                        end else if (i_rx_byte == CH_EOT) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = CH_ACK;
                            n_phase        = PH_DONE;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_TICK: begin
                if (r_phase != PH_IDLE && r_phase != PH_DONE && r_phase != PH_FAIL) begin
                    n_wait = wait_inc[TICK_W-1:0];
                    priority if (r_phase == PH_INIT) begin
                        if (wait_inc >= {1'b0, i_cfg.init_to}) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = CH_C;
                            n_wait         = '0;
                        end
                    end else if (wait_inc >= {1'b0, i_cfg.byte_to}) begin
                        if (r_phase == PH_RETRY) begin
                            n_phase = PH_FAIL;
                        end else begin
                            do_err    = 1'b1;
                            err_phase = PH_RETRY;
                        end
                    end
                end
            end
            REQ_RSVD: begin
            end
        endcase

        // Count an error: fail past the limit, else NAK
        if (do_err) begin
            n_err = r_err + ERR_W'(1);
            if (n_err > ERR_W'(i_cfg.err_limit)) begin
                n_phase = PH_FAIL;
            end else begin
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = CH_NAK;
                n_phase        = err_phase;
                n_wait         = '0;
            end
        end

        // Report the phase after this transaction
        if (n_phase == PH_DONE) begin
            o_res.status = STAT_DONE;
            o_res.length = n_len;
        end else if (n_phase == PH_FAIL) begin
            o_res.status = STAT_FAIL;
        end
    end

    // State registers advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_exp   <= 8'd1;
            r_gblk  <= '0;
            r_gcmp  <= '0;
            r_crc   <= '0;
            r_crch  <= '0;
            r_err   <= '0;
            r_wait  <= '0;
            r_len   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_exp   <= n_exp;
            r_gblk  <= n_gblk;
            r_gcmp  <= n_gcmp;
            r_crc   <= n_crc;
            r_crch  <= n_crch;
            r_err   <= n_err;
            r_wait  <= n_wait;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xcr_out_buf.sv
`default_nettype none

module xcr_out_buf
    import xcr_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire t_res                 i_res,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    output logic                      o_space,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_res                      o_res,
    output logic      [ADDR_BITS-1:0] o_wr_addr
);

    logic                 r_o_valid, r_s_valid;
    t_res                 r_o_res, r_s_res;
    logic [ADDR_BITS-1:0] r_o_addr, r_s_addr;
    logic                 pop;

    assign pop       = r_o_valid && i_ready;
    assign o_space   = !r_s_valid;
    assign o_valid   = r_o_valid;
    assign o_res     = r_o_res;
    assign o_wr_addr = r_o_addr;

    // Valid flags: output stage first, skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (pop || !r_o_valid) begin
            r_o_valid <= r_s_valid || i_push;
            r_s_valid <= 1'b0;
        end else if (i_push) begin
            r_s_valid <= 1'b1;
        end
    end

    // Payload: refill output from skid or input, park in skid on stall
    always_ff @(posedge i_clk) begin
        if (pop || !r_o_valid) begin
            if (r_s_valid) begin
                r_o_res  <= r_s_res;
                r_o_addr <= r_s_addr;
            end else begin
                r_o_res  <= i_res;
                r_o_addr <= i_wr_addr;
            end
        end else if (i_push) begin
            r_s_res  <= i_res;
            r_s_addr <= i_wr_addr;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xmodem_crc_receiver_unit.sv
`default_nettype none

// XMODEM-CRC receiver.
// i_req carries one transaction per item: start, a received UART byte, or a
// one millisecond tick. o_res returns exactly one transaction per item with
// the byte to send back (C, ACK or NAK), an optional destination write
// (address = committed length + index in block) and the transfer status.
// Configuration (capacity, error limit, init and byte timeouts) is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
// Throughput: one item per cycle while o_res takes results; the protocol state
// and the bytewise CRC update are a single pass of logic between the state
// registers and a two-entry output stage (output register plus skid register).
// Stall: while o_res is held off, one more item is accepted into the skid
// register, after which i_req.ready drops until o_res takes a result.
// Reset: synchronous, active low; the protocol returns to idle, pending
// results are dropped and the configuration takes its default values.
module xmodem_crc_receiver_unit
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    xcr_req_if.sink               i_req,
    xcr_res_if.source             o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_cfg                 r_cfg;
    t_res                 core_res, buf_res;
    logic [ADDR_BITS-1:0] core_addr;
    logic                 take;
    logic                 space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= CAP_RST;
            r_cfg.err_limit <= ERR_LIMIT_RST;
            r_cfg.init_to   <= INIT_TO_RST;
            r_cfg.byte_to   <= BYTE_TO_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAPACITY:  r_cfg.capacity  <= i_cfg_data[LEN_W-1:0];
                CFG_ERR_LIMIT: r_cfg.err_limit <= i_cfg_data[LIM_W-1:0];
                CFG_INIT_TO:   r_cfg.init_to   <= i_cfg_data[TICK_W-1:0];
                CFG_BYTE_TO:   r_cfg.byte_to   <= i_cfg_data[TICK_W-1:0];
            endcase
        end
    end

    assign i_req.ready = space;
    assign take        = i_req.valid && space;

    xcr_core #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_req_type (i_req.req_type),
        .i_rx_byte  (i_req.rx_byte),
        .i_cfg      (r_cfg),
        .o_res      (core_res),
        .o_wr_addr  (core_addr)
    );

    xcr_out_buf #(
        .ADDR_BITS (ADDR_BITS)
    ) u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (take),
        .i_res     (core_res),
        .i_wr_addr (core_addr),
        .o_space   (space),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_res     (buf_res),
        .o_wr_addr (o_res.wr_addr)
    );

    assign o_res.tx_valid = buf_res.tx_valid;
    assign o_res.tx_byte  = buf_res.tx_byte;
    assign o_res.wr_valid = buf_res.wr_valid;
    assign o_res.wr_data  = buf_res.wr_data;
    assign o_res.status   = buf_res.status;
    assign o_res.length   = buf_res.length;

    // An accepted transaction leaves a valid result on the output next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> o_res.valid)
        else $error("accepted item did not reach the output");

    // Input is held off only while a result is waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_res.valid)
        else $error("input stalled with no pending result");

    // Unused send byte reads as zero
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.tx_valid) |-> (o_res.tx_byte == 8'h00))
        else $error("tx_byte nonzero without tx_valid");

    // Length only reported with a completed transfer
    a_len_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != STAT_DONE)) |-> (o_res.length == '0))
        else $error("length reported without completion");

endmodule

`default_nettype wire

FILE: bench/xmodem_crc_receiver_unit_reply_check.sv
module xmodem_crc_receiver_unit_reply_check
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    xcr_req_if               i_req,
    xcr_res_if               i_res,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 tx_valid;
        logic [7:0]           tx_byte;
        logic                 wr_valid;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [7:0]           wr_data;
        logic [1:0]           status;
        logic [LEN_W-1:0]     length;
    } t_reply;

    t_reply pending_replies[$];

    // Mirrored configuration
    logic [LEN_W-1:0]  cap;
    logic [LIM_W-1:0]  err_lim;
    logic [TICK_W-1:0] init_to;
    logic [TICK_W-1:0] byte_to;

    // Mirrored protocol state
    t_phase           phase;
    int unsigned      blk_pos;
    logic [7:0]       next_blk;
    logic [7:0]       hdr_blk;
    logic [7:0]       hdr_inv;
    logic [7:0]       crc_hi;
    logic [CRC_W-1:0] crc_acc;
    int unsigned      err_cnt;
    int unsigned      idle_ticks;
    logic [LEN_W-1:0] stored_len;

    function automatic logic [CRC_W-1:0] crc16_update(logic [CRC_W-1:0] crc, logic [7:0] val);
        logic [CRC_W-1:0] c;
        c = crc ^ {val, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic bit block_fits();
        return longint'(stored_len) + BLOCK_BYTES <= longint'(cap);
    endfunction

    task automatic restart(input t_phase ph);
        phase      = ph;
        blk_pos    = 0;
        next_blk   = 8'd1;
        hdr_blk    = '0;
        hdr_inv    = '0;
        crc_hi     = '0;
        crc_acc    = '0;
        err_cnt    = 0;
        idle_ticks = 0;
        stored_len = '0;
    endtask

    task automatic send_back(inout t_reply r, input logic [7:0] ch);
        r.tx_valid = 1'b1;
        r.tx_byte  = ch;
    endtask

    task automatic open_block();
        phase      = PH_NUM;
        blk_pos    = 0;
        crc_acc    = '0;
        idle_ticks = 0;
    endtask

    // Count an error; past the limit fail silently, else NAK and move on
    task automatic count_error(input t_phase nxt, inout t_reply r);
        err_cnt++;
        if (err_cnt > err_lim) begin
            phase = PH_FAIL;
        end else begin
            send_back(r, CH_NAK);
            phase      = nxt;
            idle_ticks = 0;
        end
    endtask

    task automatic take_byte(input logic [7:0] val, inout t_reply r);
        case (phase)
            PH_INIT: begin
                if (val == CH_SOH) begin
                    open_block();
                end else begin
                    send_back(r, CH_C);
                    idle_ticks = 0;
                end
            end
            PH_NUM: begin
                hdr_blk    = val;
                phase      = PH_INV;
                idle_ticks = 0;
            end
            PH_INV: begin
                hdr_inv    = val;
                phase      = PH_DATA;
                idle_ticks = 0;
            end
            PH_DATA: begin
                if (block_fits()) begin
                    r.wr_valid = 1'b1;
                    r.wr_addr  = ADDR_BITS'(longint'(stored_len) + blk_pos);
                    r.wr_data  = val;
                end
                crc_acc = crc16_update(crc_acc, val);
                blk_pos++;
                if (blk_pos >= BLOCK_BYTES) phase = PH_CRCH;
                idle_ticks = 0;
            end
            PH_CRCH: begin
                crc_hi     = val;
                phase      = PH_CRCL;
                idle_ticks = 0;
            end
            PH_CRCL: begin
                if ((hdr_blk ^ hdr_inv) != 8'hFF || {crc_hi, val} != crc_acc) begin
                    count_error(PH_WAIT, r);
                end else if (hdr_blk == next_blk) begin
                    // new block: commit its bytes if they were stored
                    if (block_fits()) stored_len = stored_len + LEN_W'(BLOCK_BYTES);
                    next_blk   = next_blk + 8'd1;
                    err_cnt    = 0;
                    send_back(r, CH_ACK);
                    phase      = PH_WAIT;
                    idle_ticks = 0;
                end else if (hdr_blk == next_blk - 8'd1) begin
                    // repeat of the previous block: acknowledge, keep nothing
                    send_back(r, CH_ACK);
                    phase      = PH_WAIT;
                    idle_ticks = 0;
                end else begin
                    count_error(PH_WAIT, r);
                end
            end
            PH_WAIT, PH_RETRY: begin
                if (val == CH_SOH) begin
                    open_block();
                end else if (val == CH_EOT) begin
                    send_back(r, CH_ACK);
                    phase = PH_DONE;
                end else begin
                    count_error(PH_WAIT, r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic take_tick(inout t_reply r);
        if (phase == PH_IDLE || phase == PH_DONE || phase == PH_FAIL) return;
        idle_ticks++;
        if (phase == PH_INIT) begin
            if (idle_ticks >= init_to) begin
                send_back(r, CH_C);
                idle_ticks = 0;
            end
            return;
        end
        if (idle_ticks < byte_to) return;
        if (phase == PH_RETRY) phase = PH_FAIL;
        else count_error(PH_RETRY, r);
    endtask

    task automatic compute_reply(input t_req kind, input logic [7:0] val, output t_reply r);
        r = '0;
        case (kind)
            REQ_START: begin
                restart(PH_INIT);
                send_back(r, CH_C);
            end
            REQ_BYTE: take_byte(val, r);
            REQ_TICK: take_tick(r);
            default: ;
        endcase
        if (phase == PH_DONE) begin
            r.status = STAT_DONE;
            r.length = stored_len;
        end else if (phase == PH_FAIL) begin
            r.status = STAT_FAIL;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare replies, track configuration, predict accepted transactions
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            pending_replies.delete();
            cap     = CAP_RST;
            err_lim = ERR_LIMIT_RST;
            init_to = INIT_TO_RST;
            byte_to = BYTE_TO_RST;
            restart(PH_IDLE);
            o_fail_count = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected reply: expected none, actual tx=%0b/0x%0h wr=%0b status=%0d",
                             $time, i_res.tx_valid, i_res.tx_byte, i_res.wr_valid,
                             i_res.status);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("tx_valid", want.tx_valid, i_res.tx_valid);
                    check_field("tx_byte", want.tx_byte, i_res.tx_byte);
                    check_field("wr_valid", want.wr_valid, i_res.wr_valid);
                    check_field("wr_addr", want.wr_addr, i_res.wr_addr);
                    check_field("wr_data", want.wr_data, i_res.wr_data);
                    check_field("status", want.status, i_res.status);
                    check_field("length", want.length, i_res.length);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CAPACITY:  cap     = i_cfg_data[LEN_W-1:0];
                    CFG_ERR_LIMIT: err_lim = i_cfg_data[LIM_W-1:0];
                    CFG_INIT_TO:   init_to = i_cfg_data[TICK_W-1:0];
                    CFG_BYTE_TO:   byte_to = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                compute_reply(t_req'(i_req.req_type), i_req.rx_byte, want);
                pending_replies.push_back(want);
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

FILE: bench/xmodem_crc_receiver_unit_tb.sv
module xmodem_crc_receiver_unit_tb
    import xcr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
    localparam int ADDR_BITS   = ADDR_BITS_DEF;

    typedef enum int {BLK_GOOD, BLK_BAD_CRC, BLK_BAD_INV, BLK_SHORT} t_blk_flavor;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               items_sent;
    bit               quiet;
    logic [TICK_W-1:0] cur_init_to;
    logic [TICK_W-1:0] cur_byte_to;

    xcr_req_if                         req_ch ();
    xcr_res_if #(.ADDR_BITS(ADDR_BITS)) res_ch ();

    xmodem_crc_receiver_unit #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_res     (res_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    xmodem_crc_receiver_unit_reply_check #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_reply_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc16_xmodem(logic [15:0] crc, logic [7:0] val);
        logic [15:0] c;
        c = crc ^ {val, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Any byte that neither opens a block nor ends the transfer
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (v == CH_SOH || v == CH_EOT) v = CH_C;
        return v;
    endfunction

    // Ticks to reach a timeout; for settings above 40 a short random count of one to five
    function automatic int ticks_for(logic [TICK_W-1:0] limit);
        if (limit == 0) return 1;
        if (limit > 40) return $urandom_range(1, 5);
        return limit;
    endfunction

    // Offer one transaction, with random gaps unless quiet, and hold it until accepted
    task automatic send_item(input t_req kind, input logic [7:0] val);
        @(negedge i_clk);
        if (!quiet) begin
            while ($urandom_range(99) < 24) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.rx_byte  <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] val);
        send_item(REQ_BYTE, val);
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom_range(255)));
    endtask

    task automatic timeout_ticks();
        repeat (ticks_for(cur_byte_to)) send_tick();
    endtask

    // Stop offering and wait until every predicted reply has been taken
    task automatic drain_replies();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic set_config(input logic [LEN_W-1:0] cap, input logic [LIM_W-1:0] lim,
                              input logic [TICK_W-1:0] ito, input logic [TICK_W-1:0] bto);
        write_reg(CFG_CAPACITY, CFG_W'(cap));
        write_reg(CFG_ERR_LIMIT, CFG_W'(lim));
        write_reg(CFG_INIT_TO, CFG_W'(ito));
        write_reg(CFG_BYTE_TO, CFG_W'(bto));
        @(negedge i_clk);
        cfg_we      <= 1'b0;
        cur_init_to = ito;
        cur_byte_to = bto;
    endtask

    // One block: header, random payload, CRC, each possibly damaged
    task automatic send_block(input logic [7:0] num, input t_blk_flavor flav);
        logic [15:0] crc;
        logic [7:0]  inv;
        logic [7:0]  val;
        int          cut;
        crc = '0;
        inv = ~num;
        if (flav == BLK_BAD_INV) inv ^= 8'(1 << $urandom_range(0, 7));
        cut = (flav == BLK_SHORT) ? $urandom_range(0, BLOCK_BYTES - 1) : BLOCK_BYTES;
        send_byte(CH_SOH);
        send_byte(num);
        send_byte(inv);
        for (int k = 0; k < cut; k++) begin
            val = 8'($urandom_range(255));
            crc = crc16_xmodem(crc, val);
            send_byte(val);
            // a lone tick never times out once the byte timeout exceeds one
            if (cur_byte_to > 1 && $urandom_range(99) < 3) send_tick();
        end
        if (flav == BLK_SHORT) begin
            timeout_ticks();
        end else begin
            if (flav == BLK_BAD_CRC) crc ^= 16'(1 << $urandom_range(0, 15));
            send_byte(crc[15:8]);
            send_byte(crc[7:0]);
        end
    endtask

    // One transfer: start, init handling, one or two blocks, then EOT, timeouts or nothing
    task automatic run_transfer();
        int         roll;
        logic [7:0] blk_no;
        send_item(REQ_START, 8'($urandom_range(255)));
        roll = $urandom_range(99);
        if (roll < 30 && cur_init_to <= 10) repeat (ticks_for(cur_init_to)) send_tick();
        else if (roll < 50) send_byte(noise_byte());
        blk_no = 8'd1;
        repeat ($urandom_range(1, 2)) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                send_block(blk_no, BLK_GOOD);
                blk_no++;
            end else if (roll < 70) begin
                send_block(blk_no - 8'd1, BLK_GOOD);
            end else if (roll < 78) begin
                send_block(blk_no, BLK_BAD_CRC);
            end else if (roll < 84) begin
                send_block(blk_no, BLK_BAD_INV);
            end else if (roll < 90) begin
                send_block(blk_no + 8'($urandom_range(2, 250)), BLK_GOOD);
            end else begin
                send_block(blk_no, BLK_SHORT);
            end
            roll = $urandom_range(99);
            if (roll < 5) send_byte(noise_byte());
            else if (roll < 8) send_item(REQ_RSVD, 8'($urandom_range(255)));
            else if (roll < 12) send_tick();
        end
        roll = $urandom_range(99);
        if (roll < 80) begin
            send_byte(CH_EOT);
        end else if (roll < 90) begin
            timeout_ticks();
            timeout_ticks();
        end
    endtask

    // Result side: random stalls, one long hold-off, quiet stretches
    initial begin
        bit held_off;
        held_off     = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && items_sent >= 300) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    // Stimulus
    initial begin
        int phase_start;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.rx_byte  = 8'h00;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_CAPACITY;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        items_sent      = 0;
        quiet           = 1'b0;
        cur_init_to     = INIT_TO_RST;
        cur_byte_to     = BYTE_TO_RST;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short timeouts and a tight error limit
        set_config(CAP_RST, 4'd1, 16'd2, 16'd2);
        // ignored while idle
        send_item(REQ_RSVD, 8'hFF);
        send_byte(8'h00);
        send_tick();
        // start, init timeout, non-SOH byte resends C
        send_item(REQ_START, 8'h00);
        send_tick();
        send_tick();
        send_byte(8'hFF);
        // header timeout NAKs, second timeout fails
        send_byte(CH_SOH);
        send_byte(8'h01);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        send_byte(8'h55);
        // restart from failure; error beyond limit fails without a byte
        send_item(REQ_START, 8'hFF);
        send_byte(CH_SOH);
        send_tick();
        send_tick();
        send_byte(8'h00);
        // EOT after a NAK completes with nothing stored
        send_item(REQ_START, 8'h00);
        send_byte(CH_SOH);
        send_tick();
        send_tick();
        send_byte(CH_EOT);
        send_tick();

        // Random transfers under several settings
        for (int p = 0; p < 6; p++) begin
            drain_replies();
            quiet = (p == 2);
            case (p)
                0: set_config(CAP_RST, 4'd10, 16'd3, 16'd4);
                1: set_config('0, 4'd0, 16'd1, 16'd1);
                2: set_config(LEN_W'(256), 4'd15, 16'd0, 16'd0);
                3: set_config(LEN_W'(BLOCK_BYTES), 4'd2, 16'hFFFF, 16'hFFFF);
                4: set_config(LEN_W'($urandom), 4'($urandom), 16'($urandom_range(1, 8)),
                              16'($urandom_range(2, 8)));
                default: set_config('1, 4'd3, 16'd5, 16'd3);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 100) run_transfer();
        end

        drain_replies();
        repeat (3) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/xcr_pkg.sv
rtl/xcr_if.sv
rtl/xcr_crc_byte.sv
rtl/xcr_core.sv
rtl/xcr_out_buf.sv
rtl/xmodem_crc_receiver_unit.sv
bench/xmodem_crc_receiver_unit_reply_check.sv
bench/xmodem_crc_receiver_unit_tb.sv
